/* rtl/dtq_pkg.sv */
// Package for the delta timer queue: sizes, codes, sequencer states and index helpers.
package dtq_pkg;

	// List capacity and the widths that follow from it.
	localparam int DEPTH   = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DELTA_W = 17;
	localparam int DELAY_W = 16;
	localparam int HND_W   = 8;

	// Input action codes.
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// Result status codes.
	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK_RD,
		S_WALK_CMP,
		S_SH_RD,
		S_SH_WR,
		S_PUT,
		S_TK_RD,
		S_TK_CHK,
		S_TK_FLUSH
	} state_t;

	// Next slot of the circular list, wrapping at the end.
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] res;
		if (idx == IDX_W'(DEPTH - 1)) begin
			res = '0;
		end else begin
			res = idx + IDX_W'(1);
		end
		return res;
	endfunction

	// Previous slot of the circular list, wrapping at the start.
	function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] res;
		if (idx == '0) begin
			res = IDX_W'(DEPTH - 1);
		end else begin
			res = idx - IDX_W'(1);
		end
		return res;
	endfunction

endpackage

/* rtl/delta_timer_queue.sv */
// Delta-list timer queue with a circular entry memory and a small sequencer.
//
// Channel  | Ports                                     | Handshake
// ---------+-------------------------------------------+----------------------------------
// input    | action, delay, handle                     | word taken when start && !busy
// result   | released, released_handle, status, last   | word valid for one cycle at done
//
// An insert keeps busy high while it walks the list and, unless the new entry goes to the
// tail, while it shifts the later entries up one slot. The single read port of the entry
// memory paces both: the walk and the tail shift each handle one entry at a time. A tick
// keeps busy high while it reads the head and releases any expired entries. A full-list
// insert or a tick on an empty list is answered from idle. Reset empties the list at once;
// no clearing pass is needed. The receiver cannot stall: every result is shown for
// exactly one cycle.
module delta_timer_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [15:0] delay,
	input  logic [7:0]  handle,
	output logic        done,
	output logic        released,
	output logic [7:0]  released_handle,
	output logic        status,
	output logic        last
);
	import dtq_pkg::*;

	// Entry memory: deltas and handles, same address.
	logic [DELTA_W-1:0] delta_mem  [DEPTH];
	logic [HND_W-1:0]   handle_mem [DEPTH];

	state_t state_q, state_d;

	logic [IDX_W-1:0]   head_q, tail_q;
	logic [CNT_W-1:0]   count_q;
	logic               first_q, pend_q;
	logic [HND_W-1:0]   pend_hnd_q;
	logic [IDX_W-1:0]   ptr_q, src_q, dst_q;
	logic [CNT_W-1:0]   k_q;
	logic [DELTA_W-1:0] remain_q;
	logic [HND_W-1:0]   hnd_q;
	logic [DELTA_W-1:0] rd_delta_q;
	logic [HND_W-1:0]   rd_handle_q;

	logic               done_q, released_q, status_q, last_q;
	logic [HND_W-1:0]   released_handle_q;

	logic               accept, list_full, list_empty;
	logic               walk_ge, walk_end, sh_at_pos;
	logic [DELTA_W-1:0] tick_val;
	logic               tick_pop;

	// Outputs of the sequencer.
	logic               mem_we;
	logic [IDX_W-1:0]   wr_addr, rd_addr;
	logic [DELTA_W-1:0] wr_delta;
	logic [HND_W-1:0]   wr_handle;
	logic               emit, emit_rel, emit_status, emit_last;
	logic [HND_W-1:0]   emit_hnd;

	// Shared conditions for the sequencer.
	assign accept     = start && !busy;
	assign list_full  = (count_q == CNT_W'(DEPTH));
	assign list_empty = (count_q == '0);
	assign walk_ge    = $signed(remain_q) >= $signed(rd_delta_q);
	assign walk_end   = ((k_q + CNT_W'(1)) == count_q);
	assign sh_at_pos  = (src_q == ptr_q);
	assign tick_val   = rd_delta_q - {{(DELTA_W-1){1'b0}}, first_q};
	assign tick_pop   = tick_val[DELTA_W-1] || (tick_val == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_INSERT) begin
						if (list_empty) begin
							state_d = S_PUT;
						end else if (!list_full) begin
							state_d = S_WALK_RD;
						end
					end else if (!list_empty) begin
						state_d = S_TK_RD;
					end
				end
			end
			S_WALK_RD: state_d = S_WALK_CMP;
			S_WALK_CMP: begin
				if (walk_ge) begin
					state_d = walk_end ? S_PUT : S_WALK_RD;
				end else begin
					state_d = S_SH_RD;
				end
			end
			S_SH_RD: state_d = S_SH_WR;
			S_SH_WR: state_d = sh_at_pos ? S_PUT : S_SH_RD;
			S_PUT:   state_d = S_IDLE;
			S_TK_RD: state_d = S_TK_CHK;
			S_TK_CHK: begin
				if (!tick_pop) begin
					state_d = S_IDLE;
				end else if (count_q == CNT_W'(1)) begin
					state_d = S_TK_FLUSH;
				end else begin
					state_d = S_TK_RD;
				end
			end
			S_TK_FLUSH: state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Memory control and result words.
	always_comb begin
		mem_we      = 1'b0;
		wr_addr     = ptr_q;
		wr_delta    = remain_q;
		wr_handle   = hnd_q;
		rd_addr     = head_q;
		emit        = 1'b0;
		emit_rel    = 1'b0;
		emit_hnd    = '0;
		emit_status = STAT_OK;
		emit_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				// A full-list insert and a tick on an empty list answer at once.
				if (accept && action == ACT_INSERT && list_full) begin
					emit        = 1'b1;
					emit_status = STAT_FULL;
				end else if (accept && action == ACT_TICK && list_empty) begin
					emit = 1'b1;
				end
			end
			S_WALK_RD: rd_addr = ptr_q;
			S_SH_RD:   rd_addr = src_q;
			S_SH_WR: begin
				// Move one entry up; the one after the new slot loses the new delta.
				mem_we    = 1'b1;
				wr_addr   = dst_q;
				wr_delta  = sh_at_pos ? (rd_delta_q - remain_q) : rd_delta_q;
				wr_handle = rd_handle_q;
			end
			S_PUT: begin
				mem_we = 1'b1;
				emit   = 1'b1;
			end
			S_TK_CHK: begin
				// Write back the decremented head when it stays in the list.
				if (first_q && !tick_pop) begin
					mem_we    = 1'b1;
					wr_addr   = head_q;
					wr_delta  = tick_val;
					wr_handle = rd_handle_q;
				end
				// A held release goes out once it is known whether another follows.
				if (pend_q) begin
					emit      = 1'b1;
					emit_rel  = 1'b1;
					emit_hnd  = pend_hnd_q;
					emit_last = !tick_pop;
				end else if (!tick_pop) begin
					emit = 1'b1;
				end
			end
			S_TK_FLUSH: begin
				emit     = 1'b1;
				emit_rel = 1'b1;
				emit_hnd = pend_hnd_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Entry memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			delta_mem[wr_addr]  <= wr_delta;
			handle_mem[wr_addr] <= wr_handle;
		end
		rd_delta_q  <= delta_mem[rd_addr];
		rd_handle_q <= handle_mem[rd_addr];
	end

	// Control state: list pointers, count, tick flags and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			first_q <= 1'b0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			case (state_q)
				S_IDLE: begin
					first_q <= 1'b1;
					pend_q  <= 1'b0;
				end
				S_PUT: begin
					tail_q  <= next_idx(tail_q);
					count_q <= count_q + CNT_W'(1);
				end
				S_TK_CHK: begin
					first_q <= 1'b0;
					if (tick_pop) begin
						pend_q  <= 1'b1;
						head_q  <= next_idx(head_q);
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
					first_q <= first_q;
				end
			endcase
		end
	end

	// Walk and shift datapath, plus the result word registers.
	always_ff @(posedge clk) begin
		released_q        <= emit_rel;
		released_handle_q <= emit_hnd;
		status_q          <= emit_status;
		last_q            <= emit_last;
		case (state_q)
			S_IDLE: begin
				remain_q <= {1'b0, delay};
				hnd_q    <= handle;
				ptr_q    <= head_q;
				k_q      <= '0;
			end
			S_WALK_CMP: begin
				if (walk_ge) begin
					remain_q <= remain_q - rd_delta_q;
					ptr_q    <= next_idx(ptr_q);
					k_q      <= k_q + CNT_W'(1);
				end else begin
					src_q <= prev_idx(tail_q);
					dst_q <= tail_q;
				end
			end
			S_SH_WR: begin
				dst_q <= src_q;
				src_q <= prev_idx(src_q);
			end
			S_TK_CHK: begin
				if (tick_pop) begin
					pend_hnd_q <= rd_handle_q;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign released        = released_q;
	assign released_handle = released_handle_q;
	assign status          = status_q;
	assign last            = last_q;

	// The fill count never exceeds the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// The tail pointer sits exactly count entries after the head.
	a_tail_track: assert property (@(posedge clk) disable iff (!arst_n)
		((int'(head_q) + int'(count_q) >= DEPTH) ?
			(int'(head_q) + int'(count_q) - DEPTH) :
			(int'(head_q) + int'(count_q))) == int'(tail_q))
		else $error("tail pointer out of step with head and count");

	// A rejected insert is a single final word with no release.
	a_reject_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> last && !released)
		else $error("rejected insert word malformed");

	// A tick on an empty list answers in the next cycle without a release.
	a_empty_tick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == ACT_TICK && count_q == '0 |=> done && !released && last)
		else $error("tick on empty list not answered");

endmodule

/* tb/sv/delta_timer_queue_tb.sv */
// Self-checking testbench for the delta timer queue: directed and random insert/tick words.
`timescale 1ns / 100ps

module delta_timer_queue_tb;
	import dtq_pkg::*;

	// One pending stimulus word, with the idle cycles to wait before it and a drain flag.
	typedef struct packed {
		logic               act;
		logic [DELAY_W-1:0] dly;
		logic [HND_W-1:0]   hnd;
		int                 gap;
		bit                 settle;
	} stim_word_t;

	// One result word as seen on the result ports.
	typedef struct packed {
		logic             released;
		logic [HND_W-1:0] released_handle;
		logic             status;
		logic             last;
	} release_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               action = ACT_INSERT;
	logic [DELAY_W-1:0] delay = '0;
	logic [HND_W-1:0]   handle = '0;
	logic               busy;
	logic               done;
	logic               released;
	logic [HND_W-1:0]   released_handle;
	logic               status;
	logic               last;

	stim_word_t    stim_q[$];
	release_word_t release_q[$];
	int            error_count = 0;
	int            idle_cycles;
	int            big_delays_left = 3;

	// Driver scratch values.
	logic       launch;
	stim_word_t next_word;

	// Monitor scratch values.
	release_word_t want;

	// Our own copy of the pending timer list, head first.
	logic signed [DELTA_W-1:0] timer_delta[DEPTH];
	logic [HND_W-1:0]          timer_handle[DEPTH];
	int                        timer_count = 0;

	delta_timer_queue u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.delay           (delay),
		.handle          (handle),
		.done            (done),
		.released        (released),
		.released_handle (released_handle),
		.status          (status),
		.last            (last)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Update the timer list for one accepted word and queue the releases it causes.
	task automatic apply_word(input logic act, input logic [DELAY_W-1:0] dly,
			input logic [HND_W-1:0] hnd);
		logic signed [DELTA_W-1:0] remain;
		logic [HND_W-1:0]          expired[$];
		int                        pos;
		int                        i;
		remain = $signed({1'b0, dly});
		if (act == ACT_INSERT) begin
			if (timer_count >= DEPTH) begin
				release_q.push_back('{1'b0, '0, STAT_FULL, 1'b1});
			end else begin
				// Walk past every entry due no later than the new one.
				pos = 0;
				while (pos < timer_count && remain >= timer_delta[pos]) begin
					remain = remain - timer_delta[pos];
					pos++;
				end
				for (i = timer_count; i > pos; i--) begin
					timer_delta[i]  = timer_delta[i-1];
					timer_handle[i] = timer_handle[i-1];
				end
				// The follower keeps its absolute due time.
				if (pos < timer_count)
					timer_delta[pos+1] = timer_delta[pos+1] - remain;
				timer_delta[pos]  = remain;
				timer_handle[pos] = hnd;
				timer_count++;
				release_q.push_back('{1'b0, '0, STAT_OK, 1'b1});
			end
		end else begin
			// A tick ages the head, then every leading entry at or below zero expires.
			if (timer_count > 0) begin
				timer_delta[0] = timer_delta[0] - DELTA_W'(1);
				while (timer_count > 0 && timer_delta[0] <= 0) begin
					expired.push_back(timer_handle[0]);
					for (i = 0; i + 1 < timer_count; i++) begin
						timer_delta[i]  = timer_delta[i+1];
						timer_handle[i] = timer_handle[i+1];
					end
					timer_count--;
				end
			end
			if (expired.size() == 0) begin
				release_q.push_back('{1'b0, '0, STAT_OK, 1'b1});
			end else begin
				for (i = 0; i < expired.size(); i++)
					release_q.push_back('{1'b1, expired[i], STAT_OK,
						(i == expired.size() - 1)});
			end
		end
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(99);
		if (quiet || r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 8);
	endfunction

	task automatic add_word(input logic act, input logic [DELAY_W-1:0] dly,
			input logic [HND_W-1:0] hnd, input int gap, input bit settle);
		stim_word_t w;
		w.act    = act;
		w.dly    = dly;
		w.hnd    = hnd;
		w.gap    = gap;
		w.settle = settle;
		stim_q.push_back(w);
	endtask

	// Driver: presents the next word, holds it while busy, and records it when taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start       <= 1'b0;
			action      <= ACT_INSERT;
			delay       <= '0;
			handle      <= '0;
			idle_cycles <= 0;
		end else begin
			launch = start;
			if (start && !busy) begin
				apply_word(action, delay, handle);
				launch = 1'b0;
			end
			if (!launch && stim_q.size() != 0 && idle_cycles >= stim_q[0].gap &&
					!(stim_q[0].settle && (release_q.size() != 0 || busy))) begin
				next_word = stim_q.pop_front();
				action      <= next_word.act;
				delay       <= next_word.dly;
				handle      <= next_word.hnd;
				idle_cycles <= 0;
				launch = 1'b1;
			end else if (!launch) begin
				idle_cycles <= idle_cycles + 1;
			end
			start <= launch;
		end
	end

	// Monitor: every result word must match the oldest expected release.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (release_q.size() == 0) begin
				$display("%0t: unexpected word released=%0d handle=%02h status=%0d last=%0d",
					$time, released, released_handle, status, last);
				error_count++;
			end else begin
				want = release_q.pop_front();
				if (released !== want.released) begin
					$display("%0t: released expected %0d actual %0d",
						$time, want.released, released);
					error_count++;
				end
				if (released_handle !== want.released_handle) begin
					$display("%0t: released_handle expected %02h actual %02h",
						$time, want.released_handle, released_handle);
					error_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, status);
					error_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0d actual %0d",
						$time, want.last, last);
					error_count++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int         fill_delay[16];
		int         seg_mode;
		bit         quiet;
		int         r;
		logic       act;
		logic [DELAY_W-1:0] dly;
		fill_delay = '{65535, 0, 1, 1, 1, 2, 3, 3, 5, 4, 0, 2, 7, 6, 1, 8};

		// Directed: empty tick, zero delay, fill to capacity with ties, full reject.
		add_word(ACT_TICK, 16'h0000, 8'h00, 0, 1'b0);
		add_word(ACT_INSERT, 16'h0000, 8'h00, 0, 1'b0);
		add_word(ACT_TICK, 16'hFFFF, 8'hFF, 2, 1'b0);
		for (int i = 0; i < 16; i++)
			add_word(ACT_INSERT, DELAY_W'(fill_delay[i]),
				HND_W'((i == 0) ? 8'hFF : 8'h20 + i),
				(i < 8) ? 0 : 1, 1'b0);
		add_word(ACT_INSERT, 16'h0003, 8'hAA, 0, 1'b0);
		add_word(ACT_TICK, 16'h0000, 8'h00, 0, 1'b1);
		add_word(ACT_TICK, 16'h0000, 8'h00, 5, 1'b0);
		add_word(ACT_TICK, 16'h0000, 8'h00, 0, 1'b0);

		// Random: segments that lean toward inserts, ticks, or neither.
		for (int n = 0; n < 230; n++) begin
			if (n % 20 == 0) begin
				seg_mode = $urandom_range(2);
				quiet    = ($urandom_range(3) == 0);
			end
			r = $urandom_range(99);
			case (seg_mode)
				0: act = (r < 50) ? ACT_INSERT : ACT_TICK;
				1: act = (r < 80) ? ACT_INSERT : ACT_TICK;
				default: act = (r < 20) ? ACT_INSERT : ACT_TICK;
			endcase
			r = $urandom_range(99);
			if (r < 70) begin
				dly = DELAY_W'($urandom_range(4));
			end else if (r < 95 || big_delays_left == 0) begin
				dly = DELAY_W'($urandom_range(30));
			end else begin
				// Long timers stay in the list for good, so only a few.
				dly = DELAY_W'($urandom_range(65535, 256));
				big_delays_left--;
			end
			add_word(act, dly, HND_W'($urandom_range(255)), pick_gap(quiet),
				($urandom_range(39) == 0));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stim_q.size() != 0 || start || release_q.size() != 0)
			@(posedge clk);
		repeat (4 * DEPTH + 8) @(posedge clk);
		if (error_count == 0)
			$display("delta_timer_queue_tb OK");
		else
			$display("delta_timer_queue_tb NOT OK");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5ms;
		$display("%0t: timeout", $time);
		$display("delta_timer_queue_tb NOT OK");
		$finish;
	end

endmodule

/* delta_timer_queue.f */
rtl/dtq_pkg.sv
rtl/delta_timer_queue.sv
tb/sv/delta_timer_queue_tb.sv
